// ===== design/vertex_2d_transform_assert.svh =====
// ============================================================================
// vertex_2d_transform assertion macros
// concurrent property helpers shared by the transform pipeline
// ============================================================================
`ifndef VERTEX_2D_TRANSFORM_ASSERT_SVH
`define VERTEX_2D_TRANSFORM_ASSERT_SVH

// implication checked in the same cycle, skipped during reset
`define V2DT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// implication checked in the next cycle, active during reset too
`define V2DT_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/v2dt_pkg.sv =====
// ============================================================================
// v2dt_pkg
// types, constants and helper functions of the vertex transform pipeline
// ============================================================================
`default_nettype none

package v2dt_pkg;

    typedef enum logic [1:0] {
        MODE_TRANSLATE = 2'd0,
        MODE_SCALE     = 2'd1,
        MODE_ROTATE    = 2'd2
    } t_mode;

    localparam int FULL_TURN    = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int PI_QUOT   = int'(PI_Q30 / HALF_TURN);
    localparam int PI_REM    = int'(PI_Q30 % HALF_TURN);
    localparam int LOW_SHIFT = 8;
    localparam int DIV_LOW   = HALF_TURN >> LOW_SHIFT;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_LOW = (1 << RECIP_SHIFT) / DIV_LOW;

    localparam int ATAN_ENTRIES = 24;
    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    localparam int CORDIC_W = 36;
    localparam int ANGLE_W  = 33;
    localparam int GUARD_BITS = 16;
    localparam int SPLIT_BITS = 18;
    localparam int ROUND_SHIFT = 46;

    typedef struct packed {
        logic signed [15:0] value;
        logic               clip;
    } t_sat;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               clip;
        logic               rot;
        logic               last;
    } t_side;

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic        [12:0] mag;
        logic               neg;
        logic        [30:0] p_hi;
        logic        [17:0] v;
        t_side              side;
    } t_pre;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ANGLE_W-1:0]  z;
        t_side                      side;
    } t_cordic;

    function automatic t_sat sat16(input logic signed [32:0] v);
        t_sat s;
        if (v > 33'sd32767) begin
            s.value = 16'sh7fff;
            s.clip  = 1'b1;
        end else if (v < -33'sd32768) begin
            s.value = -16'sh8000;
            s.clip  = 1'b1;
        end else begin
            s.value = v[15:0];
            s.clip  = 1'b0;
        end
        return s;
    endfunction

    // gain correction 2^60 / isqrt(G << 30), evaluated at elaboration
    function automatic logic [31:0] gain_q30(input int n);
        logic [63:0] g;
        logic [63:0] num;
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] rem;
        logic [63:0] quo;
        int i;
        g = 64'd1 << 30;
        for (i = 0; i < n; i++) begin
            g = g + (g >> (2 * i));
        end
        num   = g << 30;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (bit_v > num) begin
                bit_v = bit_v >> 2;
            end
        end
        for (i = 0; i < 32; i++) begin
            if (bit_v != 64'd0) begin
                if (num >= res + bit_v) begin
                    num = num - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        rem = '0;
        quo = '0;
        for (i = 60; i >= 0; i--) begin
            rem = {rem[62:0], (i == 60)};
            if (rem >= res) begin
                rem    = rem - res;
                quo[i] = 1'b1;
            end
        end
        return quo[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/v2dt_if.sv =====
// ============================================================================
// v2dt stream interfaces
// valid/ready channels for vertex transactions and result transactions
// ============================================================================
`default_nettype none

interface v2dt_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  mode;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic signed [15:0] param_a;
    logic signed [15:0] param_b;
    logic signed [15:0] angle_deg;
    logic               is_last;

    modport source (
        output valid, mode, vert_x, vert_y, param_a, param_b, angle_deg, is_last,
        input  ready
    );
    modport sink (
        input  valid, mode, vert_x, vert_y, param_a, param_b, angle_deg, is_last,
        output ready
    );
endinterface

interface v2dt_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               out_last;
    logic               clipped;

    modport source (
        output valid, out_x, out_y, out_last, clipped,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_last, clipped,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/v2dt_front.sv =====
// ============================================================================
// v2dt_front
// input stages: angle reduction, quadrant fold, translate and scale paths,
// radian conversion products
// ============================================================================
`default_nettype none

module v2dt_front #(
    parameter int FRACTION_BITS = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic        [1:0]  i_mode,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    input  wire logic signed [15:0] i_a,
    input  wire logic signed [15:0] i_b,
    input  wire logic signed [15:0] i_ang,
    input  wire logic               i_last,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output v2dt_pkg::t_pre          o_data
);
    import v2dt_pkg::*;

    localparam logic signed [32:0] HalfLsb = 33'sd1 <<< (FRACTION_BITS - 1);

    logic               r1_valid;
    logic signed [31:0] r1_ax;
    logic signed [31:0] r1_ay;
    logic signed [16:0] r1_x;
    logic signed [16:0] r1_y;
    logic signed [13:0] r1_r;
    logic        [1:0]  r1_mode;
    logic               r1_last;

    logic               r2_valid;
    t_pre               r2_data;

    logic               s1_ready;
    logic               s2_ready;

    logic signed [17:0] ang_w;
    logic signed [17:0] red;
    logic               flip;
    logic signed [31:0] n_ax;
    logic signed [31:0] n_ay;

    logic signed [13:0] r_abs;
    logic        [12:0] mag;
    logic        [31:0] hi_w;
    logic        [25:0] lo_w;
    logic signed [32:0] bx;
    logic signed [32:0] by;
    t_sat               sx;
    t_sat               sy;
    t_pre               n_data;

    assign s2_ready = !r2_valid || i_ready;
    assign s1_ready = !r1_valid || s2_ready;
    assign o_ready  = s1_ready;
    assign o_valid  = r2_valid;
    assign o_data   = r2_data;

    // stage 1
    always_comb begin
        ang_w = 18'(i_ang);
        if (ang_w > 18'(HALF_TURN)) begin
            red = ang_w - 18'(FULL_TURN);
        end else if (ang_w <= -18'(HALF_TURN)) begin
            red = ang_w + 18'(FULL_TURN);
        end else begin
            red = ang_w;
        end
        flip = 1'b0;
        if (red > 18'(QUARTER_TURN)) begin
            red  = red - 18'(HALF_TURN);
            flip = 1'b1;
        end else if (red < -18'(QUARTER_TURN)) begin
            red  = red + 18'(HALF_TURN);
            flip = 1'b1;
        end
        unique case (i_mode)
            MODE_TRANSLATE: begin
                n_ax = 32'(i_x) + 32'(i_a);
                n_ay = 32'(i_y) + 32'(i_b);
            end
            MODE_SCALE: begin
                n_ax = i_x * i_a;
                n_ay = i_y * i_b;
            end
            default: begin
                n_ax = 32'(i_x);
                n_ay = 32'(i_y);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (s1_ready) begin
            r1_valid <= i_valid;
        end
        if (s1_ready && i_valid) begin
            r1_ax   <= n_ax;
            r1_ay   <= n_ay;
            r1_x    <= flip ? -17'(i_x) : 17'(i_x);
            r1_y    <= flip ? -17'(i_y) : 17'(i_y);
            r1_r    <= 14'(red);
            r1_mode <= i_mode;
            r1_last <= i_last;
        end
    end

    // stage 2
    always_comb begin
        r_abs = r1_r[13] ? -r1_r : r1_r;
        mag   = 13'(r_abs);
        hi_w  = 32'(mag) * 32'(PI_QUOT);
        lo_w  = 26'(mag) * 26'(PI_REM) + 26'(QUARTER_TURN);
        if (r1_mode == MODE_SCALE) begin
            bx = (33'(r1_ax) + HalfLsb) >>> FRACTION_BITS;
            by = (33'(r1_ay) + HalfLsb) >>> FRACTION_BITS;
        end else begin
            bx = 33'(r1_ax);
            by = 33'(r1_ay);
        end
        sx = sat16(bx);
        sy = sat16(by);
        n_data.x         = r1_x;
        n_data.y         = r1_y;
        n_data.mag       = mag;
        n_data.neg       = r1_r[13];
        n_data.p_hi      = hi_w[30:0];
        n_data.v         = lo_w[25:LOW_SHIFT];
        n_data.side.x    = sx.value;
        n_data.side.y    = sy.value;
        n_data.side.clip = sx.clip || sy.clip;
        n_data.side.rot  = (r1_mode == MODE_ROTATE);
        n_data.side.last = r1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_ready) begin
            r2_valid <= r1_valid;
        end
        if (s2_ready && r1_valid) begin
            r2_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/v2dt_angle.sv =====
// ============================================================================
// v2dt_angle
// finishes degree to radian conversion by reciprocal divide and builds
// the guarded cordic start vector
// ============================================================================
`default_nettype none

module v2dt_angle (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  v2dt_pkg::t_pre   i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output v2dt_pkg::t_cordic o_data
);
    import v2dt_pkg::*;

    logic        r3_valid;
    t_pre        r3_data;
    logic [12:0] r3_q0;

    logic        r4_valid;
    t_cordic     r4_data;

    logic        s3_ready;
    logic        s4_ready;

    logic [36:0] qp;
    logic [17:0] rem;
    logic        corr;
    logic [31:0] zmag;
    t_cordic     n_data;

    assign s4_ready = !r4_valid || i_ready;
    assign s3_ready = !r3_valid || s4_ready;
    assign o_ready  = s3_ready;
    assign o_valid  = r4_valid;
    assign o_data   = r4_data;

    // quotient estimate, low by at most one
    assign qp = 37'(i_data.v) * 37'(RECIP_LOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (s3_ready) begin
            r3_valid <= i_valid;
        end
        if (s3_ready && i_valid) begin
            r3_data <= i_data;
            r3_q0   <= qp[36:RECIP_SHIFT];
        end
    end

    always_comb begin
        rem    = r3_data.v - (18'(r3_q0) * 18'(DIV_LOW));
        corr   = (rem >= 18'(DIV_LOW));
        zmag   = 32'(r3_data.p_hi) + 32'(r3_q0) + 32'(corr);
        n_data.z    = r3_data.neg ? -ANGLE_W'(zmag) : ANGLE_W'(zmag);
        n_data.x    = CORDIC_W'(r3_data.x) <<< GUARD_BITS;
        n_data.y    = CORDIC_W'(r3_data.y) <<< GUARD_BITS;
        n_data.side = r3_data.side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (s4_ready) begin
            r4_valid <= r3_valid;
        end
        if (s4_ready && r3_valid) begin
            r4_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/v2dt_cordic_stage.sv =====
// ============================================================================
// v2dt_cordic_stage
// one registered cordic micro-rotation in rotation mode
// ============================================================================
`default_nettype none

module v2dt_cordic_stage #(
    parameter int          SHIFT = 0,
    parameter logic [31:0] ATAN  = 32'h0
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  v2dt_pkg::t_cordic i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output v2dt_pkg::t_cordic o_data
);
    import v2dt_pkg::*;

    localparam logic signed [ANGLE_W-1:0] AtanW = ANGLE_W'(ATAN);

    logic    r_valid;
    t_cordic r_data;
    t_cordic n_data;

    logic signed [CORDIC_W-1:0] cx;
    logic signed [CORDIC_W-1:0] cy;
    logic signed [ANGLE_W-1:0]  cz;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        cx = i_data.x;
        cy = i_data.y;
        cz = i_data.z;
        dx = cy >>> SHIFT;
        dy = cx >>> SHIFT;
        n_data.side = i_data.side;
        if (!cz[ANGLE_W-1]) begin
            n_data.x = cx - dx;
            n_data.y = cy + dy;
            n_data.z = cz - AtanW;
        end else begin
            n_data.x = cx + dx;
            n_data.y = cy - dy;
            n_data.z = cz + AtanW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/v2dt_gain.sv =====
// ============================================================================
// v2dt_gain
// cordic gain correction by split partial products, rounding, saturation
// and the result register
// ============================================================================
`default_nettype none

module v2dt_gain #(
    parameter int STAGES = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  v2dt_pkg::t_cordic i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output v2dt_pkg::t_side   o_data
);
    import v2dt_pkg::*;

    localparam logic signed [31:0] GainK = gain_q30(STAGES);
    localparam int HiW = CORDIC_W - SPLIT_BITS;
    localparam int ProdW = SPLIT_BITS + 32;
    localparam int AccW = 68;
    localparam logic signed [AccW-1:0] RoundK = AccW'(1) <<< (ROUND_SHIFT - 1);

    logic                    g1_valid;
    logic signed [ProdW-1:0] r_pxh;
    logic        [ProdW-1:0] r_pxl;
    logic signed [ProdW-1:0] r_pyh;
    logic        [ProdW-1:0] r_pyl;
    t_side                   r_side;

    logic                    g2_valid;
    t_side                   r_out;

    logic                    s1_ready;
    logic                    s2_ready;

    logic signed [HiW-1:0]   xh;
    logic signed [HiW-1:0]   yh;
    logic        [SPLIT_BITS-1:0] xl;
    logic        [SPLIT_BITS-1:0] yl;
    logic signed [AccW-1:0]  acc_x;
    logic signed [AccW-1:0]  acc_y;
    t_sat                    sx;
    t_sat                    sy;
    t_side                   n_out;

    assign s2_ready = !g2_valid || i_ready;
    assign s1_ready = !g1_valid || s2_ready;
    assign o_ready  = s1_ready;
    assign o_valid  = g2_valid;
    assign o_data   = r_out;

    assign xh = i_data.x[CORDIC_W-1:SPLIT_BITS];
    assign yh = i_data.y[CORDIC_W-1:SPLIT_BITS];
    assign xl = i_data.x[SPLIT_BITS-1:0];
    assign yl = i_data.y[SPLIT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            g1_valid <= 1'b0;
        end else if (s1_ready) begin
            g1_valid <= i_valid;
        end
        if (s1_ready && i_valid) begin
            r_pxh  <= ProdW'(xh) * ProdW'(GainK);
            r_pyh  <= ProdW'(yh) * ProdW'(GainK);
            r_pxl  <= ProdW'(xl) * ProdW'(GainK);
            r_pyl  <= ProdW'(yl) * ProdW'(GainK);
            r_side <= i_data.side;
        end
    end

    always_comb begin
        acc_x = (AccW'(r_pxh) <<< SPLIT_BITS) + AccW'(r_pxl) + RoundK;
        acc_y = (AccW'(r_pyh) <<< SPLIT_BITS) + AccW'(r_pyl) + RoundK;
        sx = sat16(33'($signed(acc_x[AccW-1:ROUND_SHIFT])));
        sy = sat16(33'($signed(acc_y[AccW-1:ROUND_SHIFT])));
        n_out = r_side;
        if (r_side.rot) begin
            n_out.x    = sx.value;
            n_out.y    = sy.value;
            n_out.clip = sx.clip || sy.clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            g2_valid <= 1'b0;
        end else if (s2_ready) begin
            g2_valid <= g1_valid;
        end
        if (s2_ready && g1_valid) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== design/vertex_2d_transform.sv =====
// ============================================================================
// vertex_2d_transform
// translate, scale or cordic rotate one q4.12 vertex per transaction,
// with saturation flag and last marker passed through
// ============================================================================
// channel  dir  modport  payload
// i_in     in   sink     mode, vert_x, vert_y, param_a, param_b, angle_deg, is_last
// o_out    out  source   out_x, out_y, out_last, clipped
//
// one transaction per cycle sustained while o_out is ready, every mode takes the same path
// stages in order: two front stages, two angle stages, one register per cordic
// micro-rotation, two gain stages
// reset clears the valid bit of every stage only
// each stage holds while its successor is full and stalled; empty stages
// keep accepting, so bubbles close up under back pressure
// ============================================================================
`default_nettype none

module vertex_2d_transform #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRACTION_BITS = 12
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    v2dt_in_if.sink       i_in,
    v2dt_out_if.source    o_out
);
    import v2dt_pkg::*;

    `include "vertex_2d_transform_assert.svh"

    localparam int Stages = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

    logic    w_pre_valid;
    logic    w_pre_ready;
    t_pre    w_pre_data;

    logic    w_cv [Stages+1];
    logic    w_cr [Stages+1];
    t_cordic w_cd [Stages+1];

    t_side   w_res;

    v2dt_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_mode  (i_in.mode),
        .i_x     (i_in.vert_x),
        .i_y     (i_in.vert_y),
        .i_a     (i_in.param_a),
        .i_b     (i_in.param_b),
        .i_ang   (i_in.angle_deg),
        .i_last  (i_in.is_last),
        .o_valid (w_pre_valid),
        .i_ready (w_pre_ready),
        .o_data  (w_pre_data)
    );

    v2dt_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pre_valid),
        .o_ready (w_pre_ready),
        .i_data  (w_pre_data),
        .o_valid (w_cv[0]),
        .i_ready (w_cr[0]),
        .o_data  (w_cd[0])
    );

    for (genvar g = 0; g < Stages; g++) begin : g_cordic
        v2dt_cordic_stage #(
            .SHIFT (g),
            .ATAN  (ATAN_Q30[g])
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[g]),
            .o_ready (w_cr[g]),
            .i_data  (w_cd[g]),
            .o_valid (w_cv[g+1]),
            .i_ready (w_cr[g+1]),
            .o_data  (w_cd[g+1])
        );
    end

    v2dt_gain #(
        .STAGES (Stages)
    ) u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cv[Stages]),
        .o_ready (w_cr[Stages]),
        .i_data  (w_cd[Stages]),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_res)
    );

    assign o_out.out_x    = w_res.x;
    assign o_out.out_y    = w_res.y;
    assign o_out.out_last = w_res.last;
    assign o_out.clipped  = w_res.clip;

    `V2DT_ASSERT_NEXT(a_reset_empties, i_clk, !i_rst_n, !o_out.valid)
    `V2DT_ASSERT_NOW(a_clip_at_rail, i_clk, i_rst_n, o_out.valid && o_out.clipped,
        (o_out.out_x == 16'sh7fff) || (o_out.out_x == -16'sh8000) ||
        (o_out.out_y == 16'sh7fff) || (o_out.out_y == -16'sh8000))
    `V2DT_ASSERT_NOW(a_pre_hold, i_clk, i_rst_n,
        $past(w_pre_valid && !w_pre_ready) && $past(i_rst_n),
        w_pre_valid && $stable(w_pre_data))

endmodule

`default_nettype wire

// ===== tb/sv/tb_vertex_2d_transform.sv =====
// ============================================================================
// tb_vertex_2d_transform
// streams directed and random vertex transactions through the transform
// pipeline under varying source and sink idling, including two long sink
// hold-offs, and checks every result against a bit-exact local predictor
// ============================================================================
`default_nettype none

module tb_vertex_2d_transform;
    timeunit 1ns;
    timeprecision 1ps;

    import v2dt_pkg::*;

    localparam int          STAGES       = 16;
    localparam int          FRAC_BITS    = 12;
    localparam int          USED_STAGES  = (STAGES > 24) ? 24 : STAGES;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam longint      TURN_FULL    = 23040;
    localparam longint      TURN_HALF    = 11520;
    localparam longint      TURN_QUARTER = 5760;
    localparam longint      PI_RAD_Q30   = 64'd3373259426;
    localparam int          RANDOM_ITEMS = 1050;
    localparam int          DRAIN_CYCLES = 2 * (STAGES + 6) + 16;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          HOLD_CYCLES  = 160;

    localparam longint ARC_TAN_Q30 [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    typedef struct packed {
        logic        [1:0]  mode;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] ang;
        logic               last;
    } t_vertex;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        logic               clip;
    } t_result;

    class vertex_scoreboard;
        t_result pending_results[$];
        int      errors;
        longint  gain_corr;

        function new();
            longint unsigned g;
            int i;
            errors = 0;
            g = 64'd1 << 30;
            for (i = 0; i < USED_STAGES; i++) begin
                g = g + (g >> (2 * i));
            end
            gain_corr = longint'((64'd1 << 60) / int_sqrt(g << 30));
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function logic signed [15:0] clamp16(longint v, inout bit clip);
            if (v > 32767) begin
                clip = 1'b1;
                return 16'sh7fff;
            end
            if (v < -32768) begin
                clip = 1'b1;
                return 16'sh8000;
            end
            return v[15:0];
        endfunction

        function t_result transform_vertex(t_vertex v);
            longint  x;
            longint  y;
            longint  rx;
            longint  ry;
            longint  r;
            longint  mag;
            longint  z;
            longint  cx;
            longint  cy;
            longint  dx;
            longint  dy;
            bit      clip;
            int      i;
            t_result res;
            x    = v.x;
            y    = v.y;
            rx   = x;
            ry   = y;
            clip = 1'b0;
            case (v.mode)
                MODE_TRANSLATE: begin
                    rx = x + longint'(v.a);
                    ry = y + longint'(v.b);
                end
                MODE_SCALE: begin
                    rx = (x * longint'(v.a) + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                    ry = (y * longint'(v.b) + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                end
                MODE_ROTATE: begin
                    r = (longint'(v.ang) + 2 * TURN_FULL) % TURN_FULL;
                    if (r > TURN_HALF) r = r - TURN_FULL;
                    // fold into the cordic convergence range
                    if (r > TURN_QUARTER) begin
                        r = r - TURN_HALF;
                        x = -x;
                        y = -y;
                    end else if (r < -TURN_QUARTER) begin
                        r = r + TURN_HALF;
                        x = -x;
                        y = -y;
                    end
                    mag = (r < 0) ? -r : r;
                    z   = (mag * PI_RAD_Q30 + TURN_HALF / 2) / TURN_HALF;
                    if (r < 0) z = -z;
                    cx = x <<< 16;
                    cy = y <<< 16;
                    for (i = 0; i < USED_STAGES; i++) begin
                        dx = cy >>> i;
                        dy = cx >>> i;
                        if (z >= 0) begin
                            cx = cx - dx;
                            cy = cy + dy;
                            z  = z - ARC_TAN_Q30[i];
                        end else begin
                            cx = cx + dx;
                            cy = cy - dy;
                            z  = z + ARC_TAN_Q30[i];
                        end
                    end
                    rx = (cx * gain_corr + (longint'(1) <<< 45)) >>> 46;
                    ry = (cy * gain_corr + (longint'(1) <<< 45)) >>> 46;
                end
                default: begin
                end
            endcase
            res.x    = clamp16(rx, clip);
            res.y    = clamp16(ry, clip);
            res.last = v.last;
            res.clip = clip;
            return res;
        endfunction

        function void note_vertex(t_vertex v);
            pending_results.push_back(transform_vertex(v));
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected: x %0d y %0d",
                       got.x, got.y);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.x !== exp.x) begin
                $error("out_x mismatch: expected %0d, actual %0d", exp.x, got.x);
                errors++;
            end
            if (got.y !== exp.y) begin
                $error("out_y mismatch: expected %0d, actual %0d", exp.y, got.y);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("out_last mismatch: expected %0b, actual %0b", exp.last, got.last);
                errors++;
            end
            if (got.clip !== exp.clip) begin
                $error("clipped mismatch: expected %0b, actual %0b", exp.clip, got.clip);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    int     cycles = 0;
    int     n_accepted = 0;
    int     src_idle_pct = 18;
    int     snk_idle_pct = 48;
    int     hold_left = 0;
    bit     early_hold_done = 1'b0;
    bit     late_hold_done = 1'b0;

    vertex_scoreboard sb = new();

    v2dt_in_if  in_ch ();
    v2dt_out_if out_ch ();

    vertex_2d_transform #(
        .CORDIC_STAGES (STAGES),
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL vertex_2d_transform");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.note_vertex('{in_ch.mode, in_ch.vert_x, in_ch.vert_y, in_ch.param_a,
                                 in_ch.param_b, in_ch.angle_deg, in_ch.is_last});
                n_accepted++;
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result('{out_ch.out_x, out_ch.out_y, out_ch.out_last,
                                  out_ch.clipped});
            end
        end
    end

    // sink side, with long hold-offs so the pipeline fills and stalls its input
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!early_hold_done && n_accepted >= 300) begin
                early_hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!late_hold_done && n_accepted >= 950) begin
                late_hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n || hold_left > 0) begin
                out_ch.ready <= 1'b0;
                if (hold_left > 0) hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic drive_vertex(input logic [1:0] m, input logic signed [15:0] x,
                                input logic signed [15:0] y, input logic signed [15:0] a,
                                input logic signed [15:0] b, input logic signed [15:0] ang,
                                input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= m;
        in_ch.vert_x    <= x;
        in_ch.vert_y    <= y;
        in_ch.param_a   <= a;
        in_ch.param_b   <= b;
        in_ch.angle_deg <= ang;
        in_ch.is_last   <= last;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    initial begin
        logic        [1:0]  m;
        logic signed [15:0] f [5];
        int                 i;
        int                 k;
        in_ch.valid     <= 1'b0;
        in_ch.mode      <= MODE_TRANSLATE;
        in_ch.vert_x    <= '0;
        in_ch.vert_y    <= '0;
        in_ch.param_a   <= '0;
        in_ch.param_b   <= '0;
        in_ch.angle_deg <= '0;
        in_ch.is_last   <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        drive_vertex(MODE_TRANSLATE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 1'b0);
        drive_vertex(MODE_TRANSLATE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 1'b1);
        drive_vertex(MODE_TRANSLATE, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 0, 1'b0);
        drive_vertex(MODE_TRANSLATE, 0, 0, 0, 0, 16'sh7fff, 1'b0);
        drive_vertex(MODE_SCALE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 0, 1'b0);
        drive_vertex(MODE_SCALE, 16'sh7fff, 16'sh8000, 16'sh1000, 16'sh1000, 0, 1'b1);
        drive_vertex(MODE_SCALE, 1, -1, 16'sh0800, 16'sh0800, 0, 1'b0);
        drive_vertex(MODE_SCALE, 3, -3, 16'sh0800, 16'sh0800, 0, 1'b0);
        drive_vertex(MODE_SCALE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 1'b0);
        drive_vertex(MODE_ROTATE, 16'sh1000, 16'sh0800, 0, 0, 0, 1'b0);
        drive_vertex(MODE_ROTATE, 16'sh1000, 16'sh0800, 0, 0, 5760, 1'b0);
        drive_vertex(MODE_ROTATE, 16'sh1000, 16'sh0800, 0, 0, -5760, 1'b0);
        drive_vertex(MODE_ROTATE, 16'sh1000, 16'sh0800, 0, 0, 5761, 1'b0);
        drive_vertex(MODE_ROTATE, 16'sh1000, 16'sh0800, 0, 0, -5761, 1'b0);
        drive_vertex(MODE_ROTATE, 16'sh8000, 16'sh8000, 0, 0, 11520, 1'b0);
        drive_vertex(MODE_ROTATE, 16'sh8000, 16'sh7fff, 0, 0, -11520, 1'b1);
        drive_vertex(MODE_ROTATE, 16'sh7fff, 16'sh7fff, 0, 0, 2880, 1'b0);
        drive_vertex(MODE_ROTATE, 16'sh7fff, 16'sh8000, 0, 0, 23040, 1'b0);
        drive_vertex(MODE_ROTATE, 16'sh2000, -16'sh2000, 0, 0, -23040, 1'b0);
        drive_vertex(MODE_ROTATE, 16'sh4000, 16'sh0100, 0, 0, 16'sh7fff, 1'b0);
        drive_vertex(MODE_ROTATE, 16'sh4000, 16'sh0100, 0, 0, 16'sh8000, 1'b0);
        drive_vertex(MODE_ROTATE, 0, 0, 16'sh7fff, 16'sh8000, 1234, 1'b0);
        drive_vertex(MODE_UNUSED, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 5760, 1'b1);
        drive_vertex(MODE_UNUSED, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 0, 1'b0);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                src_idle_pct = 48;
                snk_idle_pct = 18;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            k = $urandom_range(15);
            m = (k == 15) ? MODE_UNUSED : 2'(k % 3);
            for (k = 0; k < 4; k++) begin
                if ($urandom_range(3) == 0) f[k] = 16'($urandom);
                else f[k] = 16'(int'($urandom_range(16383)) - 8192);
            end
            if ($urandom_range(7) == 0) f[4] = 16'($urandom);
            else f[4] = 16'(int'($urandom_range(46080)) - 23040);
            drive_vertex(m, f[0], f[1], f[2], f[3], f[4], ($urandom_range(7) == 0));
        end
        in_ch.valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASS vertex_2d_transform");
        end else begin
            $display("FAIL vertex_2d_transform");
        end
        $finish;
    end

endmodule

`default_nettype wire
